[rtl/ttta_pkg.sv]
// Shared constants and helpers for the tick touch and tamper alarm block.
// Holds the configuration register map, reset values and saturating counters.
// No dependencies.
`timescale 1ns / 1ps

package ttta_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  // Configuration register indexes; byte address is 4 * index.
  localparam logic [IDX_W-1:0] REG_FIRST_TOUCH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SECOND_TOUCH = 3'd1;
  localparam logic [IDX_W-1:0] REG_THIRD_TOUCH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_STAGE_WINDOW = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIRE_CUT     = 3'd4;
  localparam logic [IDX_W-1:0] REG_POS_QUALIFY  = 3'd5;
  localparam logic [IDX_W-1:0] REG_HOLD_TICKS   = 3'd6;

  localparam logic [7:0]  RST_FIRST_TOUCH  = 8'd2;
  localparam logic [7:0]  RST_SECOND_TOUCH = 8'd2;
  localparam logic [7:0]  RST_THIRD_TOUCH  = 8'd1;
  localparam logic [15:0] RST_STAGE_WINDOW = 16'd4000;
  localparam logic [7:0]  RST_WIRE_CUT     = 8'd50;
  localparam logic [7:0]  RST_POS_QUALIFY  = 8'd10;
  localparam logic [15:0] RST_HOLD_TICKS   = 16'd4000;

  localparam logic [7:0]  MAX8  = 8'hFF;
  localparam logic [15:0] MAX16 = 16'hFFFF;

  function automatic logic [7:0] sat_inc8(logic [7:0] v);
    return (v == MAX8) ? v : v + 8'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == MAX16) ? v : v + 16'd1;
  endfunction

endpackage

[rtl/tick_touch_tamper_alarm.sv]
// Tick touch and tamper alarm qualifier: touch machine, cut wire latch,
// position qualifiers and one-shot hold timer, with an APB register port.
// Depends on ttta_pkg.
`timescale 1ns / 1ps

//  Channel   Signals                                   Direction
//  ticks     in_valid, in_ready, vibration .. done     into block
//  results   out_valid, out_ready, touch_first .. hold out of block
//  config    psel, penable, pwrite, paddr, pwdata,     APB, 32-bit
//            prdata, pready
//
// One tick is taken per clock cycle unless the output stalls; its result appears
// in the output register on the next cycle, computed by a single pass over the
// state registers. The result register is the only stage, so a new tick is taken
// whenever the output is empty or being taken in the same cycle.
// Synchronous reset clears the tick state and out_valid and loads the register defaults.
// While out_ready is low with a result waiting, in_ready drops and all tick state holds.

module tick_touch_tamper_alarm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        vibration,
  input  logic                        raised_active,
  input  logic                        fell_active,
  input  logic                        wire_cut,
  input  logic                        touch_enable,
  input  logic                        position_enable,
  input  logic                        alarm_busy,
  input  logic                        alarm_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        touch_first,
  output logic                        touch_second,
  output logic                        alarm_request,
  output logic                        raised_state,
  output logic                        fell_state,
  output logic                        raised_fell_active,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttta_pkg::ADDR_W-1:0] paddr,
  input  logic [ttta_pkg::DATA_W-1:0] pwdata,
  output logic [ttta_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [1:0] {
    STG_IDLE   = 2'd0,
    STG_FIRST  = 2'd1,
    STG_SECOND = 2'd2
  } stage_t;

  // Configuration registers.
  logic [7:0]  first_touch_ticks, second_touch_ticks, third_touch_ticks;
  logic [15:0] stage_window_ticks, raised_fell_hold_ticks;
  logic [7:0]  wire_cut_ticks, position_qualify_ticks;

  // Tick state.
  stage_t      touch_stage, touch_stage_next;
  logic [7:0]  first_count, first_count_next;
  logic [7:0]  second_count, second_count_next;
  logic [7:0]  third_count, third_count_next;
  logic [15:0] second_window, second_window_next;
  logic [15:0] third_window, third_window_next;
  logic [7:0]  cut_count, cut_count_next;
  logic        alarm_flag, alarm_flag_next;
  logic        third_touch_flag, third_touch_flag_next;
  logic [7:0]  raise_ticks, raise_ticks_next;
  logic [7:0]  fall_ticks, fall_ticks_next;
  logic        raised_latch, raised_latch_next;
  logic        fell_latch, fell_latch_next;
  logic        hold_flag, hold_flag_next;
  logic        hold_done_once, hold_done_once_next;
  logic [15:0] hold_ticks, hold_ticks_next;
  logic        pulse1, pulse2;

  logic                       in_accept;
  logic                       cfg_write;
  logic [ttta_pkg::IDX_W-1:0] cfg_idx;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[ttta_pkg::ADDR_W-1:2];

  always_comb begin
    unique case (cfg_idx)
      ttta_pkg::REG_FIRST_TOUCH:  prdata = {24'd0, first_touch_ticks};
      ttta_pkg::REG_SECOND_TOUCH: prdata = {24'd0, second_touch_ticks};
      ttta_pkg::REG_THIRD_TOUCH:  prdata = {24'd0, third_touch_ticks};
      ttta_pkg::REG_STAGE_WINDOW: prdata = {16'd0, stage_window_ticks};
      ttta_pkg::REG_WIRE_CUT:     prdata = {24'd0, wire_cut_ticks};
      ttta_pkg::REG_POS_QUALIFY:  prdata = {24'd0, position_qualify_ticks};
      ttta_pkg::REG_HOLD_TICKS:   prdata = {16'd0, raised_fell_hold_ticks};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_touch_ticks      <= ttta_pkg::RST_FIRST_TOUCH;
      second_touch_ticks     <= ttta_pkg::RST_SECOND_TOUCH;
      third_touch_ticks      <= ttta_pkg::RST_THIRD_TOUCH;
      stage_window_ticks     <= ttta_pkg::RST_STAGE_WINDOW;
      wire_cut_ticks         <= ttta_pkg::RST_WIRE_CUT;
      position_qualify_ticks <= ttta_pkg::RST_POS_QUALIFY;
      raised_fell_hold_ticks <= ttta_pkg::RST_HOLD_TICKS;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        ttta_pkg::REG_FIRST_TOUCH:  first_touch_ticks      <= pwdata[7:0];
        ttta_pkg::REG_SECOND_TOUCH: second_touch_ticks     <= pwdata[7:0];
        ttta_pkg::REG_THIRD_TOUCH:  third_touch_ticks      <= pwdata[7:0];
        ttta_pkg::REG_STAGE_WINDOW: stage_window_ticks     <= pwdata[15:0];
        ttta_pkg::REG_WIRE_CUT:     wire_cut_ticks         <= pwdata[7:0];
        ttta_pkg::REG_POS_QUALIFY:  position_qualify_ticks <= pwdata[7:0];
        ttta_pkg::REG_HOLD_TICKS:   raised_fell_hold_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Next state for one tick, in the order: done clear, touch machine and cut
  // wire, position qualifiers, hold timer.
  always_comb begin
    touch_stage_next      = touch_stage;
    first_count_next      = first_count;
    second_count_next     = second_count;
    third_count_next      = third_count;
    second_window_next    = second_window;
    third_window_next     = third_window;
    cut_count_next        = cut_count;
    alarm_flag_next       = alarm_flag;
    third_touch_flag_next = third_touch_flag;
    raise_ticks_next      = raise_ticks;
    fall_ticks_next       = fall_ticks;
    raised_latch_next     = raised_latch;
    fell_latch_next       = fell_latch;
    hold_flag_next        = hold_flag;
    hold_done_once_next   = hold_done_once;
    hold_ticks_next       = hold_ticks;
    pulse1                = 1'b0;
    pulse2                = 1'b0;

    if (alarm_done) begin
      alarm_flag_next       = 1'b0;
      third_touch_flag_next = 1'b0;
    end

    if (!raised_active && !fell_active && touch_enable) begin
      unique case (touch_stage)
        STG_IDLE: begin
          if (vibration && !alarm_busy) begin
            first_count_next = ttta_pkg::sat_inc8(first_count);
            if (first_count_next >= first_touch_ticks) begin
              first_count_next = 8'd0;
              touch_stage_next = STG_FIRST;
              pulse1           = 1'b1;
            end
          end else begin
            first_count_next = 8'd0;
          end
        end
        STG_FIRST: begin
          if (vibration) begin
            second_count_next = ttta_pkg::sat_inc8(second_count);
            if (second_count_next >= second_touch_ticks) begin
              second_count_next = 8'd0;
              touch_stage_next  = STG_SECOND;
              pulse2            = 1'b1;
            end
          end else begin
            second_count_next = 8'd0;
          end
          // The timeout wins over a move to stage two in the same tick.
          second_window_next = ttta_pkg::sat_inc16(second_window);
          if (second_window_next >= stage_window_ticks) begin
            touch_stage_next   = STG_IDLE;
            second_count_next  = 8'd0;
            first_count_next   = 8'd0;
            second_window_next = 16'd0;
          end
        end
        STG_SECOND: begin
          if (vibration) begin
            third_count_next = ttta_pkg::sat_inc8(third_count);
            if (third_count_next >= third_touch_ticks) begin
              third_count_next      = 8'd0;
              alarm_flag_next       = 1'b1;
              third_touch_flag_next = 1'b1;
            end
          end else begin
            third_count_next = 8'd0;
          end
          third_window_next = ttta_pkg::sat_inc16(third_window);
          if (third_window_next >= stage_window_ticks) begin
            touch_stage_next   = STG_IDLE;
            first_count_next   = 8'd0;
            second_count_next  = 8'd0;
            second_window_next = 16'd0;
            third_window_next  = 16'd0;
            third_count_next   = 8'd0;
          end
        end
        default: ;
      endcase

      // The counter stops one past the limit; a limit of 255 never latches.
      if (wire_cut && (cut_count <= wire_cut_ticks)) begin
        cut_count_next = ttta_pkg::sat_inc8(cut_count);
        if (cut_count_next > wire_cut_ticks) begin
          alarm_flag_next = 1'b1;
          cut_count_next  = (wire_cut_ticks == ttta_pkg::MAX8) ? ttta_pkg::MAX8
                                                               : wire_cut_ticks + 8'd1;
        end
      end else if (!wire_cut && !third_touch_flag_next) begin
        cut_count_next  = 8'd0;
        alarm_flag_next = 1'b0;
      end
    end

    if (position_enable) begin
      if (raised_active) begin
        if (raise_ticks != ttta_pkg::MAX8) begin
          raise_ticks_next = raise_ticks + 8'd1;
          if (raise_ticks_next == position_qualify_ticks) begin
            raised_latch_next = 1'b1;
            fell_latch_next   = 1'b0;
            if (!hold_done_once) begin
              hold_flag_next = 1'b1;
            end
          end
        end
      end else begin
        raised_latch_next = 1'b0;
        raise_ticks_next  = 8'd0;
        hold_flag_next    = 1'b0;
      end
      if (fell_active) begin
        if (fall_ticks != ttta_pkg::MAX8) begin
          fall_ticks_next = fall_ticks + 8'd1;
          if (fall_ticks_next == position_qualify_ticks) begin
            fell_latch_next   = 1'b1;
            raised_latch_next = 1'b0;
            if (!hold_done_once) begin
              hold_flag_next = 1'b1;
            end
          end
        end
      end else begin
        fell_latch_next = 1'b0;
        fall_ticks_next = 8'd0;
        hold_flag_next  = 1'b0;
      end
    end

    if (hold_flag_next) begin
      hold_ticks_next = ttta_pkg::sat_inc16(hold_ticks);
      if (hold_ticks_next >= raised_fell_hold_ticks) begin
        hold_flag_next      = 1'b0;
        hold_ticks_next     = 16'd0;
        hold_done_once_next = 1'b1;
        touch_stage_next    = STG_IDLE;
        first_count_next    = 8'd0;
        second_count_next   = 8'd0;
        second_window_next  = 16'd0;
        third_window_next   = 16'd0;
        third_count_next    = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_stage      <= STG_IDLE;
      first_count      <= 8'd0;
      second_count     <= 8'd0;
      third_count      <= 8'd0;
      second_window    <= 16'd0;
      third_window     <= 16'd0;
      cut_count        <= 8'd0;
      alarm_flag       <= 1'b0;
      third_touch_flag <= 1'b0;
      raise_ticks      <= 8'd0;
      fall_ticks       <= 8'd0;
      raised_latch     <= 1'b0;
      fell_latch       <= 1'b0;
      hold_flag        <= 1'b0;
      hold_done_once   <= 1'b0;
      hold_ticks       <= 16'd0;
      out_valid        <= 1'b0;
    end else if (in_accept) begin
      touch_stage        <= touch_stage_next;
      first_count        <= first_count_next;
      second_count       <= second_count_next;
      third_count        <= third_count_next;
      second_window      <= second_window_next;
      third_window       <= third_window_next;
      cut_count          <= cut_count_next;
      alarm_flag         <= alarm_flag_next;
      third_touch_flag   <= third_touch_flag_next;
      raise_ticks        <= raise_ticks_next;
      fall_ticks         <= fall_ticks_next;
      raised_latch       <= raised_latch_next;
      fell_latch         <= fell_latch_next;
      hold_flag          <= hold_flag_next;
      hold_done_once     <= hold_done_once_next;
      hold_ticks         <= hold_ticks_next;
      out_valid          <= 1'b1;
      touch_first        <= pulse1;
      touch_second       <= pulse2;
      alarm_request      <= alarm_flag_next;
      raised_state       <= raised_latch_next;
      fell_state         <= fell_latch_next;
      raised_fell_active <= hold_flag_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
